// ===== hw/rtl/ile_pkg.sv =====
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 5;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    // Compare width wide enough for both a position and a count
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_WRITE  = 2'd3;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Cell commands broadcast along the row
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]  entry_count;
    } t_out_rsp;

    typedef struct packed {
        logic [1:0]            kind;
        logic [POS_W-1:0]      position;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/ile_cell.sv =====
`timescale 1ns / 1ps

module ile_cell (
    input  logic                             i_clk,
    input  ile_pkg::t_cell_cmd               i_cmd,
    input  logic [ile_pkg::IDX_W-1:0]        i_index,
    input  logic [ile_pkg::DATA_WIDTH-1:0]   i_left,
    input  logic [ile_pkg::DATA_WIDTH-1:0]   i_right,
    output logic [ile_pkg::DATA_WIDTH-1:0]   o_data
);

    logic [ile_pkg::DATA_WIDTH-1:0] r_data;
    logic [ile_pkg::DATA_WIDTH-1:0] n_data;
    logic [ile_pkg::CMP_W-1:0]      idx_ext;
    logic [ile_pkg::CMP_W-1:0]      pos_ext;
    logic                           hit;
    logic                           above;

    assign idx_ext = ile_pkg::CMP_W'(i_index);
    assign pos_ext = ile_pkg::CMP_W'(i_cmd.position);
    assign hit     = (idx_ext == pos_ext);
    assign above   = (idx_ext > pos_ext);

    always_comb begin
        n_data = r_data;
        case (i_cmd.kind)
            ile_pkg::CMD_OPEN: begin
                if (hit) begin
                    n_data = i_cmd.value;
                end else if (above) begin
                    n_data = i_left;
                end
            end
            ile_pkg::CMD_CLOSE: begin
                if (hit || above) begin
                    n_data = i_right;
                end
            end
            ile_pkg::CMD_WRITE: begin
                if (hit) begin
                    n_data = i_cmd.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/ile_ctrl.sv =====
`timescale 1ns / 1ps

module ile_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  ile_pkg::t_in_req               i_req,
    input  logic [ile_pkg::DATA_WIDTH-1:0] i_cell_data [ile_pkg::CAPACITY],
    output ile_pkg::t_cell_cmd             o_cmd,
    output ile_pkg::t_out_rsp              o_rsp
);

    logic [ile_pkg::CNT_W-1:0]      r_count;
    logic [ile_pkg::CNT_W-1:0]      n_count;
    logic [ile_pkg::CMP_W-1:0]      cnt_ext;
    logic [ile_pkg::CMP_W-1:0]      pos_ext;
    logic [1:0]                     kind;
    logic [ile_pkg::STAT_W-1:0]     status;
    logic [ile_pkg::DATA_WIDTH-1:0] rd_data;
    logic                           do_read;

    assign cnt_ext = ile_pkg::CMP_W'(r_count);
    assign pos_ext = ile_pkg::CMP_W'(i_req.position);

    always_comb begin
        kind    = ile_pkg::CMD_HOLD;
        status  = ile_pkg::ST_OK;
        n_count = r_count;
        do_read = 1'b0;
        case (i_req.op)
            ile_pkg::OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status = ile_pkg::ST_RANGE;
                end else if (cnt_ext == ile_pkg::CMP_W'(ile_pkg::CAPACITY)) begin
                    status = ile_pkg::ST_FULL;
                end else begin
                    kind    = ile_pkg::CMD_OPEN;
                    n_count = r_count + 1'b1;
                end
            end
            ile_pkg::OP_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    status = ile_pkg::ST_RANGE;
                end else begin
                    kind    = ile_pkg::CMD_CLOSE;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                if (pos_ext > cnt_ext) begin
                    status = ile_pkg::ST_RANGE;
                end else if (r_count == '0) begin
                    status = ile_pkg::ST_EMPTY;
                end else if (pos_ext == cnt_ext) begin
                    status = ile_pkg::ST_RANGE;
                end else if (i_req.op == ile_pkg::OP_READ) begin
                    do_read = 1'b1;
                end else begin
                    kind = ile_pkg::CMD_WRITE;
                end
            end
        endcase
    end

    // Position is below count on a good read, so the low bits index a live cell
    always_comb begin
        rd_data = '0;
        if (do_read) begin
            rd_data = i_cell_data[i_req.position[ile_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_cmd.kind     = i_accept ? kind : ile_pkg::CMD_HOLD;
    assign o_cmd.position = i_req.position;
    assign o_cmd.value    = ile_pkg::DATA_WIDTH'(i_req.value);

    assign o_rsp.status      = status;
    assign o_rsp.read_value  = ile_pkg::VAL_W'(rd_data);
    assign o_rsp.entry_count = ile_pkg::POS_W'(n_count);

endmodule

// ===== hw/rtl/indexed_list_engine.sv =====
// Response: an accepted request's response is loaded into the output register.
// Throughput: one request per cycle while not stalled; every cell of the row
// shifts, loads or holds in the same cycle; the entry count updates alongside.
// Reset (synchronous, active low) empties the list and drops any pending
// response; stored words are not cleared and never read before written.
`timescale 1ns / 1ps

module indexed_list_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ile_pkg::t_in_req     i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output ile_pkg::t_out_rsp    o_rsp
);

    logic                           accept;
    ile_pkg::t_cell_cmd             cmd;
    ile_pkg::t_out_rsp              rsp;
    logic [ile_pkg::DATA_WIDTH-1:0] cell_data [ile_pkg::CAPACITY];

    logic                           r_out_valid;
    ile_pkg::t_out_rsp              r_rsp;

    // Stall new requests only while a finished response is held back
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Decode the request, keep the entry count, pick the read word
    ile_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cell_data (cell_data),
        .o_cmd       (cmd),
        .o_rsp       (rsp)
    );

    // Row of cells: cell k holds list position k. Insert opens a gap by
    // shifting every cell above the position up from its left neighbor;
    // remove closes it by pulling from the right neighbor. The front cell has
    // no left neighbor and the last cell pulls its own word on a remove.
    for (genvar k = 0; k < ile_pkg::CAPACITY; k++) begin : g_cell
        logic [ile_pkg::DATA_WIDTH-1:0] left_data;
        logic [ile_pkg::DATA_WIDTH-1:0] right_data;

        if (k == 0) begin : g_front
            assign left_data = '0;
        end else begin : g_mid_left
            assign left_data = cell_data[k-1];
        end

        if (k == ile_pkg::CAPACITY - 1) begin : g_back
            assign right_data = cell_data[k];
        end else begin : g_mid_right
            assign right_data = cell_data[k+1];
        end

        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_index (ile_pkg::IDX_W'(k)),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[k])
        );
    end

    // Output register: load on accept, release when the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== sim/indexed_list_engine_tb.sv =====
`timescale 1ns / 1ps

module indexed_list_engine_tb;

    localparam int N_RANDOM   = 1750;
    localparam int TAIL_ITEMS = 150;   // no idling on either side for the last requests
    localparam int HOLD_AFTER = 600;   // accepted requests before the long receiver hold
    localparam int HOLD_LEN   = 64;

    typedef enum logic [1:0] { MOOD_GROW, MOOD_SHRINK, MOOD_MIXED } t_mood;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_stall = 1'b0;
    ile_pkg::t_in_req  i_req   = '0;
    logic              o_stall;
    logic              o_valid;
    ile_pkg::t_out_rsp o_rsp;

    indexed_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    ile_pkg::t_in_req  pending_reqs[$];
    ile_pkg::t_out_rsp expected_rsps[$];

    // shadow copy of the list
    logic [ile_pkg::DATA_WIDTH-1:0] list_words [ile_pkg::CAPACITY];
    int                             list_len = 0;

    int   n_total     = 0;
    int   n_accepted  = 0;
    int   n_fail      = 0;
    int   plan_len    = 0;   // list length as seen by the stimulus builder
    int   tx_gap_left = 0;
    int   rx_gap_left = 0;
    logic req_taken   = 1'b0;
    logic rx_hold     = 1'b0;
    logic quiet_tail;

    assign quiet_tail = (n_accepted + TAIL_ITEMS >= n_total);

    function automatic ile_pkg::t_out_rsp apply_list_op(ile_pkg::t_in_req req);
        ile_pkg::t_out_rsp rsp;
        int                pos;
        int                i;
        rsp = '0;
        pos = req.position;
        case (req.op)
            ile_pkg::OP_INSERT: begin
                if (pos > list_len) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else if (list_len >= ile_pkg::CAPACITY) begin
                    rsp.status = ile_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = req.value[ile_pkg::DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            ile_pkg::OP_REMOVE: begin
                if (pos >= list_len) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default: begin
                if (pos > list_len) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else if (list_len == 0) begin
                    rsp.status = ile_pkg::ST_EMPTY;
                end else if (pos == list_len) begin
                    rsp.status = ile_pkg::ST_RANGE;
                end else if (req.op == ile_pkg::OP_READ) begin
                    rsp.read_value = ile_pkg::VAL_W'(list_words[pos]);
                end else begin
                    list_words[pos] = req.value[ile_pkg::DATA_WIDTH-1:0];
                end
            end
        endcase
        rsp.entry_count = ile_pkg::POS_W'(list_len);
        return rsp;
    endfunction

    // queue a request and track the length it leaves behind
    task automatic queue_req(logic [1:0] op, logic [ile_pkg::POS_W-1:0] pos,
                             logic [ile_pkg::VAL_W-1:0] val);
        ile_pkg::t_in_req req;
        req.op       = op;
        req.position = pos;
        req.value    = val;
        pending_reqs.push_back(req);
        if (op == ile_pkg::OP_INSERT && pos <= plan_len && plan_len < ile_pkg::CAPACITY)
            plan_len++;
        if (op == ile_pkg::OP_REMOVE && pos < plan_len) plan_len--;
    endtask

    // sender: hold a stalled request, otherwise advance or idle
    always @(negedge i_clk) begin : drive_req
        logic             nxt_valid;
        ile_pkg::t_in_req nxt_req;
        nxt_valid = i_valid;
        nxt_req   = i_req;
        if (i_rst_n && !(i_valid && !req_taken)) begin
            nxt_valid = 1'b0;
            if (tx_gap_left > 0) begin
                tx_gap_left--;
            end else if (pending_reqs.size() > 0) begin
                if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    tx_gap_left = $urandom_range(0, 7);
                end else begin
                    nxt_valid = 1'b1;
                    nxt_req   = pending_reqs.pop_front();
                end
            end
        end
        i_valid <= nxt_valid;
        i_req   <= nxt_req;
    end

    // receiver: random stall bursts plus the long hold
    always @(negedge i_clk) begin : drive_stall
        if (rx_gap_left == 0 && !quiet_tail && $urandom_range(0, 6) == 0)
            rx_gap_left = $urandom_range(1, 8);
        i_stall <= rx_hold || (rx_gap_left != 0);
        if (rx_gap_left != 0) rx_gap_left--;
    end

    initial begin : long_hold
        wait (n_accepted >= HOLD_AFTER);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // check responses against the oldest expectation, then record new requests
    always @(posedge i_clk) begin : watch
        ile_pkg::t_out_rsp want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: unexpected response status=%0d value=%h count=%0d",
                                 $realtime, o_rsp.status, o_rsp.read_value, o_rsp.entry_count);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.read_value !== want.read_value
                            || o_rsp.entry_count !== want.entry_count) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("%0t: mismatch exp status=%0d value=%h count=%0d, %s%0d %s%h %s%0d",
                                     $realtime, want.status, want.read_value, want.entry_count,
                                     "got status=", o_rsp.status, "value=", o_rsp.read_value,
                                     "count=", o_rsp.entry_count);
                    end
                end
            end
            req_taken = i_valid && !o_stall;
            if (req_taken) begin
                expected_rsps.push_back(apply_list_op(i_req));
                n_accepted++;
            end
        end else begin
            req_taken = 1'b0;
        end
    end

    initial begin : run
        t_mood                     mood;
        int                        k;
        int                        roll;
        logic [1:0]                op;
        logic [ile_pkg::POS_W-1:0] pos;
        logic [ile_pkg::VAL_W-1:0] val;
        mood = MOOD_MIXED;

        // empty-list corner cases
        queue_req(ile_pkg::OP_READ,   0,  32'h1234_5678);
        queue_req(ile_pkg::OP_WRITE,  0,  32'hFFFF_FFFF);
        queue_req(ile_pkg::OP_READ,   31, 32'h0);
        queue_req(ile_pkg::OP_REMOVE, 0,  32'h0);
        queue_req(ile_pkg::OP_INSERT, 1,  32'hDEAD_BEEF);
        // single entry: access at count, then drop the only entry
        queue_req(ile_pkg::OP_INSERT, 0,  32'hFFFF_FFFF);
        queue_req(ile_pkg::OP_READ,   1,  32'h0);
        queue_req(ile_pkg::OP_READ,   0,  32'h0);
        queue_req(ile_pkg::OP_REMOVE, 0,  32'h0);
        // fill from both ends, then push past full
        for (k = 0; k < ile_pkg::CAPACITY; k++)
            queue_req(ile_pkg::OP_INSERT, (k % 2) ? ile_pkg::POS_W'(plan_len) : '0, $urandom);
        queue_req(ile_pkg::OP_INSERT, 0,  32'h5555_5555);
        queue_req(ile_pkg::OP_INSERT, 17, 32'hAAAA_AAAA);
        queue_req(ile_pkg::OP_WRITE,  15, 32'h0);
        queue_req(ile_pkg::OP_READ,   15, 32'h0);
        queue_req(ile_pkg::OP_REMOVE, 15, 32'h0);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 50 == 0) mood = t_mood'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            case (mood)
                MOOD_GROW:   op = (roll < 55) ? ile_pkg::OP_INSERT :
                                  (roll < 70) ? ile_pkg::OP_REMOVE :
                                  (roll < 85) ? ile_pkg::OP_READ : ile_pkg::OP_WRITE;
                MOOD_SHRINK: op = (roll < 15) ? ile_pkg::OP_INSERT :
                                  (roll < 60) ? ile_pkg::OP_REMOVE :
                                  (roll < 80) ? ile_pkg::OP_READ : ile_pkg::OP_WRITE;
                default:     op = 2'($urandom_range(0, 3));
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 8)
                pos = ile_pkg::POS_W'($urandom_range(0, 31));
            else if (roll < 18)
                pos = ile_pkg::POS_W'(plan_len);
            else if (roll < 28)
                pos = '0;
            else if (op == ile_pkg::OP_INSERT)
                pos = ile_pkg::POS_W'($urandom_range(0, plan_len));
            else
                pos = (plan_len == 0) ? '0 : ile_pkg::POS_W'($urandom_range(0, plan_len - 1));
            roll = $urandom_range(0, 19);
            val = (roll == 0) ? '0 : (roll == 1) ? '1 : ile_pkg::VAL_W'($urandom);
            queue_req(op, pos, val);
        end
        n_total = pending_reqs.size();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_total);
        wait (expected_rsps.size() == 0);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && expected_rsps.size() == 0) begin
            $display("indexed_list_engine test passed");
        end else begin
            $display("indexed_list_engine test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("indexed_list_engine test failed");
        $finish;
    end

endmodule
